@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/hct_pkg.sv @@
// Package: widths, constants and control structs of the divisor-count block
`timescale 1ns / 1ps

package hct_pkg;

	localparam int VALUE_BITS = 12;
	// trial divisor reaches floor(sqrt(n)) + 1
	localparam int I_BITS     = VALUE_BITS / 2 + 1;
	// remainder unit also divides by the sieve step
	localparam int D_BITS     = (I_BITS > 6) ? I_BITS : 6;
	localparam int SQ_BITS    = VALUE_BITS + 1;
	localparam int CNT_BITS   = VALUE_BITS / 2 + 2;
	localparam int COUNT_BITS = 7;
	localparam int SAT_BITS   = (CNT_BITS > COUNT_BITS) ? CNT_BITS : COUNT_BITS;
	localparam int CMP_BITS   = (VALUE_BITS > 6) ? VALUE_BITS : 6;
	localparam int BIT_BITS   = $clog2(VALUE_BITS);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = COUNT_BITS'(127);
	localparam logic [CMP_BITS-1:0]   SIEVE_STEP = CMP_BITS'(60);
	localparam logic [D_BITS-1:0]     SIEVE_DIV  = D_BITS'(60);

	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] dividend;
		logic [D_BITS-1:0]     divisor;
	} rem_req_t;

	typedef struct packed {
		logic              done;
		logic [D_BITS-1:0] rem;
	} rem_rsp_t;

	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] value;
		logic [CNT_BITS-1:0]   limit;
		logic                  use_limit;
	} cnt_req_t;

	typedef struct packed {
		logic                done;
		logic [CNT_BITS-1:0] count;
		logic                hit;
	} cnt_rsp_t;

endpackage

@@ hw/rtl/hct_ifs.sv @@
// Handshake channel interfaces for the number and result words
`timescale 1ns / 1ps

interface hct_req_if;
	logic                          valid;
	logic                          ready;
	logic [hct_pkg::VALUE_BITS-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

interface hct_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [hct_pkg::COUNT_BITS-1:0] divisor_count;
	logic                          is_record;

	modport source (output valid, output divisor_count, output is_record, input ready);
	modport sink (input valid, input divisor_count, input is_record, output ready);
endinterface

@@ hw/rtl/hct_rem.sv @@
// Shared restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module hct_rem (
	input  logic              clk,
	input  logic              arst_n,
	input  hct_pkg::rem_req_t req,
	output hct_pkg::rem_rsp_t rsp
);
	import hct_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [BIT_BITS-1:0]   bit_q;
	logic [VALUE_BITS-1:0] dvd_q;
	logic [D_BITS-1:0]     dvs_q;
	logic [D_BITS-1:0]     rem_q;

	logic [D_BITS:0]   trial;
	logic              fits;
	logic [D_BITS-1:0] rem_next;

	assign trial    = {rem_q, dvd_q[VALUE_BITS-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign rem_next = fits ? D_BITS'(trial - {1'b0, dvs_q}) : trial[D_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bit_q  <= BIT_BITS'(VALUE_BITS - 1);
			end else if (busy_q) begin
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

@@ hw/rtl/hct_divcnt.sv @@
// Divisor counter: walks trial divisors up to sqrt(n) over the remainder unit
`timescale 1ns / 1ps

module hct_divcnt (
	input  logic              clk,
	input  logic              arst_n,
	input  hct_pkg::cnt_req_t req,
	output hct_pkg::cnt_rsp_t rsp,
	output hct_pkg::rem_req_t rem_req,
	input  hct_pkg::rem_rsp_t rem_rsp
);
	import hct_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WAIT
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CNT_BITS-1:0]   limit_q;
	logic                  use_limit_q;
	logic [I_BITS-1:0]     i_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  done_q;

	logic                in_range;
	logic [CNT_BITS-1:0] cnt_next;

	assign in_range = sq_q <= SQ_BITS'(value_q);
	// a square root divisor pairs with itself
	assign cnt_next = cnt_q + ((sq_q == SQ_BITS'(value_q)) ? CNT_BITS'(1) : CNT_BITS'(2));

	assign rem_req.start    = (state_q == ST_CHECK) && in_range;
	assign rem_req.dividend = value_q;
	assign rem_req.divisor  = D_BITS'(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			value_q     <= '0;
			limit_q     <= '0;
			use_limit_q <= 1'b0;
			i_q         <= '0;
			sq_q        <= '0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						value_q     <= req.value;
						limit_q     <= req.limit;
						use_limit_q <= req.use_limit;
						i_q         <= I_BITS'(1);
						sq_q        <= SQ_BITS'(1);
						cnt_q       <= '0;
						state_q     <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (in_range) begin
						state_q <= ST_WAIT;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_WAIT: begin
					if (rem_rsp.done) begin
						if (rem_rsp.rem == '0) begin
							cnt_q <= cnt_next;
						end
						// stop early once the count reaches the limit
						if (rem_rsp.rem == '0 && use_limit_q && cnt_next >= limit_q) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							sq_q    <= sq_q + SQ_BITS'({i_q, 1'b1});
							state_q <= ST_CHECK;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.count = cnt_q;
	assign rsp.hit   = use_limit_q && (cnt_q >= limit_q);

endmodule

@@ hw/rtl/highly_composite_test.sv @@
// Counting n runs one trial remainder at a time on the shared remainder unit,
// for each trial divisor from 1 up to floor(sqrt(n)).
// Record test repeats the count for every j below n when n is 2..60 even or a
// multiple of 60, stopping at the first j whose count reaches that of n.
// One word in flight; ready again once the result sits in the output register.
// Reset clears all control state; no clearing pass.
`timescale 1ns / 1ps

module highly_composite_test (
	input  logic clk,
	input  logic arst_n,
	hct_req_if.sink   request,
	hct_rsp_if.source result
);
	import hct_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CNT,
		ST_CNT_WAIT,
		ST_MOD,
		ST_MOD_WAIT,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_FIN
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [VALUE_BITS-1:0] j_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  rec_q;
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic                  out_rec_q;

	cnt_req_t dc_req;
	cnt_rsp_t dc_rsp;
	rem_req_t dc_rem_req;
	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	logic                  mod_start;
	logic                  out_load;
	logic [SAT_BITS-1:0]   cnt_wide;
	logic [COUNT_BITS-1:0] cnt_sat;

	assign request.ready = (state_q == ST_IDLE);

	assign dc_req.start     = (state_q == ST_CNT) || ((state_q == ST_SCAN) && (j_q < v_q));
	assign dc_req.value     = (state_q == ST_CNT) ? v_q : j_q;
	assign dc_req.limit     = cnt_q;
	assign dc_req.use_limit = (state_q == ST_SCAN);

	// sieve check borrows the remainder unit while the counter is idle
	assign mod_start        = (state_q == ST_MOD);
	assign rem_req.start    = dc_rem_req.start || mod_start;
	assign rem_req.dividend = mod_start ? v_q : dc_rem_req.dividend;
	assign rem_req.divisor  = mod_start ? SIEVE_DIV : dc_rem_req.divisor;

	assign cnt_wide = SAT_BITS'(cnt_q);
	assign cnt_sat  = (cnt_wide > SAT_BITS'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(cnt_wide);

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	hct_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	hct_divcnt u_divcnt (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (dc_req),
		.rsp     (dc_rsp),
		.rem_req (dc_rem_req),
		.rem_rsp (rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			rec_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_count_q <= '0;
			out_rec_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (request.valid) begin
						v_q     <= request.number;
						state_q <= ST_CNT;
					end
				end
				ST_CNT: begin
					state_q <= ST_CNT_WAIT;
				end
				ST_CNT_WAIT: begin
					if (dc_rsp.done) begin
						cnt_q <= dc_rsp.count;
						if (v_q == VALUE_BITS'(1)) begin
							rec_q   <= 1'b1;
							state_q <= ST_FIN;
						end else if (v_q[0]) begin
							rec_q   <= 1'b0;
							state_q <= ST_FIN;
						end else if (CMP_BITS'(v_q) > SIEVE_STEP) begin
							state_q <= ST_MOD;
						end else begin
							j_q     <= VALUE_BITS'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_MOD: begin
					state_q <= ST_MOD_WAIT;
				end
				ST_MOD_WAIT: begin
					if (rem_rsp.done) begin
						if (rem_rsp.rem != '0) begin
							rec_q   <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							j_q     <= VALUE_BITS'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (j_q >= v_q) begin
						rec_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_SCAN_WAIT;
					end
				end
				ST_SCAN_WAIT: begin
					if (dc_rsp.done) begin
						if (dc_rsp.hit) begin
							rec_q   <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_FIN: begin
					if (out_load) begin
						out_count_q <= cnt_sat;
						out_rec_q   <= rec_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid         = out_valid_q;
	assign result.divisor_count = out_count_q;
	assign result.is_record     = out_rec_q;

endmodule

@@ hw/rtl/hct_checker.sv @@
// Port-level checker for the divisor-count block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hct_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hct_pkg::COUNT_BITS-1:0] out_count,
	input logic                          out_rec
);
	import hct_pkg::*;

	// ready is low in the cycle after a word is accepted
	`HCT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready right after accept")

	`HCT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_count) && $stable(out_rec), "stalled result changed")

	// only zero has no divisors, and zero counts as a record
	`HCT_ASSERT_IMPL(a_zero_is_record, clk, arst_n, out_valid && (out_count == '0), out_rec, "zero count without record flag")

endmodule

bind highly_composite_test hct_checker u_hct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (request.valid),
	.in_ready  (request.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_count (result.divisor_count),
	.out_rec   (result.is_record)
);

@@ dv/testbench.sv @@
// Testbench for highly_composite_test: divisor count and record flag, checked word by word
`timescale 1ns / 1ps

module testbench;
	import hct_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_WORDS = 100;
	localparam int DRAIN_CYCLES = 64;
	localparam int REPORT_MAX   = 10;
	localparam int SIEVE        = int'(SIEVE_STEP);

	typedef struct {
		logic [VALUE_BITS-1:0] number;
		logic [COUNT_BITS-1:0] divisor_count;
		logic                  is_record;
	} count_word_t;

	class divisor_scoreboard;
		int unsigned divs[];
		int          best_below[];
		count_word_t awaited[$];
		int unsigned failures;
		int unsigned reports;

		function new();
			int unsigned span;
			span = 1 << VALUE_BITS;
			divs = new[span];
			best_below = new[span];
			failures = 0;
			reports = 0;
			foreach (divs[k])
				divs[k] = 0;
			for (int unsigned i = 1; i < span; i++)
				for (int unsigned j = i; j < span; j += i)
					divs[j]++;
			// most divisors among 1..v-1, -1 when that range is empty
			best_below[0] = -1;
			if (span > 1)
				best_below[1] = -1;
			for (int unsigned v = 2; v < span; v++)
				best_below[v] = (int'(divs[v-1]) > best_below[v-1]) ?
					int'(divs[v-1]) : best_below[v-1];
		endfunction

		function void note_number(logic [VALUE_BITS-1:0] number);
			count_word_t word;
			int unsigned v;
			v = number;
			word.number = number;
			word.divisor_count = (divs[v] > COUNT_MAX) ? COUNT_MAX : COUNT_BITS'(divs[v]);
			if (v == 1)
				word.is_record = 1'b1;
			else if (number[0])
				word.is_record = 1'b0;
			else if (v > SIEVE && (v % SIEVE) != 0)
				word.is_record = 1'b0;
			else
				word.is_record = int'(divs[v]) > best_below[v];
			awaited = {awaited, word};
		endfunction

		function void check_result(logic [COUNT_BITS-1:0] divisor_count, logic is_record);
			count_word_t word;
			if (awaited.size() == 0) begin
				failures++;
				reports++;
				if (reports <= REPORT_MAX)
					$display("unexpected result word: divisor_count %0d is_record %0b",
						divisor_count, is_record);
				return;
			end
			word = awaited.pop_front();
			if (divisor_count !== word.divisor_count || is_record !== word.is_record) begin
				failures++;
				reports++;
				if (reports <= REPORT_MAX)
					$display("mismatch for %0d: divisor_count exp %0d got %0d, is_record exp %0b got %0b",
						word.number, word.divisor_count, divisor_count, word.is_record, is_record);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady_send;

	hct_req_if number_ch();
	hct_rsp_if count_ch();

	highly_composite_test DUT (
		.clk(clk),
		.arst_n(arst_n),
		.request(number_ch),
		.result(count_ch)
	);

	divisor_scoreboard count_board;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Large multiples of 60 trigger a scan over every smaller value, so they stay small here
	function automatic logic [VALUE_BITS-1:0] pick_number();
		int roll;
		int unsigned v;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			v = $urandom_range(0, (1 << VALUE_BITS) - 1);
			if (v % SIEVE == 0 && v > 6 * SIEVE)
				v = v | 1;
		end else if (roll < 65) begin
			v = 2 * $urandom_range(0, SIEVE / 2 + 1);
		end else if (roll < 80) begin
			v = SIEVE * $urandom_range(1, 6);
		end else if (roll < 90) begin
			v = 2 * $urandom_range(SIEVE / 2 + 1, (1 << (VALUE_BITS - 1)) - 1);
			if (v % SIEVE == 0)
				v = v + 2;
		end else begin
			v = 2 * $urandom_range(0, (1 << (VALUE_BITS - 1)) - 1) + 1;
		end
		return VALUE_BITS'(v);
	endfunction

	// Called just after a rising edge; returns at the edge that accepts the word
	task automatic send_number(input logic [VALUE_BITS-1:0] value);
		int gap;
		gap = steady_send ? 0 : pick_gap();
		if (gap > 0) begin
			number_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.number <= value;
		do
			@(posedge clk);
		while (!number_ch.ready);
		count_board.note_number(value);
	endtask

	initial begin
		int hold;
		count_ch.ready <= 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && count_ch.valid && count_ch.ready)
				count_board.check_result(count_ch.divisor_count, count_ch.is_record);
			if (hold > 0) begin
				hold--;
			end else if (count_ch.ready) begin
				hold = pick_gap();
				if (hold > 0)
					count_ch.ready <= 1'b0;
				else
					hold = $urandom_range(0, 30);
			end else begin
				count_ch.ready <= 1'b1;
				hold = $urandom_range(1, 24);
			end
		end
	end

	initial begin
		logic [VALUE_BITS-1:0] directed[$];
		number_ch.valid <= 1'b0;
		number_ch.number <= '0;
		arst_n <= 1'b0;
		steady_send = 1'b0;
		count_board = new();
		// zero, one, odd rejects, small records, multiples of 60 that pass and tie,
		// even values above 60 off the sieve step, and the field extremes
		directed = '{0, 1, 2, 3, 4, 6, 12, 24, 36, 48, 60, 62, 64, 120, 180, 240, 360,
			600, 720, 2047, 2048, 2730, 4094, 4095};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[k])
			send_number(directed[k]);
		for (int k = 0; k < RANDOM_WORDS; k++) begin
			steady_send = ((k / 16) % 2) == 1;
			send_number(pick_number());
		end
		number_ch.valid <= 1'b0;
		while (count_board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (count_board.failures == 0)
			$display("highly_composite_test regression: pass");
		else
			$display("highly_composite_test regression: fail");
		$finish;
	end

	// Watchdog that fails a run outlasting the slowest legal run of this stimulus
	initial begin
		#480_000_000;
		$display("highly_composite_test regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/hct_pkg.sv
hw/rtl/hct_ifs.sv
hw/rtl/hct_rem.sv
hw/rtl/hct_divcnt.sv
hw/rtl/highly_composite_test.sv
hw/rtl/hct_checker.sv
dv/testbench.sv
